// ===== rtl/penc_pkg.sv =====
// Shared types, constants and helpers of the percent encoder.
// No dependencies; imported by every module of the block.
package penc_pkg;

  localparam int CHAR_W      = 21;
  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int KEEP_W      = 256;
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ESC_CODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_SOURCE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_SET_W0 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_SET_W1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_SET_W2 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_SET_W3 = 3'd5;

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] UNI_MAX      = 21'h10FFFF;
  localparam logic [CHAR_W-1:0] REPLACEMENT  = 21'h00FFFD;

  typedef struct packed {
    logic [BYTE_W-1:0] esc_code;
    logic              wide_source;
    logic [KEEP_W-1:0] keep_set;   // bit n keeps character n
  } cfg_t;

  // one classified character: up to four source bytes
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [1:0]             last_idx;  // index of final source byte
    logic                   keep;      // pass bytes[0] through unescaped
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [BYTE_W-1:0] hex_upper(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    if (nib < 4'd10) r = 8'h30 + {4'd0, nib};
    else             r = 8'h37 + {4'd0, nib};
    return r;
  endfunction

endpackage

// ===== rtl/penc_front.sv =====
// Front end: accepts characters and classifies them into descriptors.
// Depends on penc_pkg.
module penc_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [penc_pkg::CHAR_W-1:0]  char_value,
  input  penc_pkg::cfg_t               cfg,
  input  penc_pkg::q_stat_t            q_stat,
  output logic                         push,
  output penc_pkg::desc_t              desc
);
  import penc_pkg::*;

  logic [CHAR_W-1:0] cp;

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

  // out-of-range code points map to U+FFFD
  assign cp = (char_value > UNI_MAX) ? REPLACEMENT : char_value;

  always_comb begin
    desc          = '0;
    desc.bytes[0] = char_value[7:0];
    if (!cfg.wide_source || char_value < 21'h80) begin
      desc.keep     = cfg.keep_set[char_value[7:0]];
      desc.last_idx = 2'd0;
    end else if (cp < 21'h800) begin
      desc.bytes[0] = {3'b110, cp[10:6]};
      desc.bytes[1] = {2'b10, cp[5:0]};
      desc.last_idx = 2'd1;
    end else if (cp < 21'h10000) begin
      desc.bytes[0] = {4'b1110, cp[15:12]};
      desc.bytes[1] = {2'b10, cp[11:6]};
      desc.bytes[2] = {2'b10, cp[5:0]};
      desc.last_idx = 2'd2;
    end else begin
      desc.bytes[0] = {5'b11110, cp[20:18]};
      desc.bytes[1] = {2'b10, cp[17:12]};
      desc.bytes[2] = {2'b10, cp[11:6]};
      desc.bytes[3] = {2'b10, cp[5:0]};
      desc.last_idx = 2'd3;
    end
  end

endmodule

// ===== rtl/penc_fifo.sv =====
// Short descriptor queue between front and back end.
// Depends on penc_pkg.
module penc_fifo #(
  parameter int DEPTH = penc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  penc_pkg::desc_t    wr_desc,
  input  logic               pop,
  output penc_pkg::desc_t    rd_desc,
  output penc_pkg::q_stat_t  q_stat
);
  import penc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t           mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign rd_desc      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/penc_back.sv =====
// Back end: walks the head descriptor, one output byte a cycle while m_tready is high.
// Depends on penc_pkg.
module penc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  penc_pkg::cfg_t                cfg,
  input  penc_pkg::desc_t               head,
  input  penc_pkg::q_stat_t             q_stat,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [penc_pkg::BYTE_W-1:0]   m_tdata,
  output logic                          m_tlast
);
  import penc_pkg::*;

  typedef enum logic [2:0] {
    PH_ESC = 3'b001,
    PH_HI  = 3'b010,
    PH_LO  = 3'b100
  } phase_t;

  phase_t            phase, phase_next;
  logic [1:0]        idx, idx_next;
  logic [BYTE_W-1:0] cur, beat;
  logic              beat_last, load;

  assign cur       = head.bytes[idx];
  assign load      = !q_stat.empty && (!m_tvalid || m_tready);
  assign beat_last = head.keep || (phase == PH_LO && idx == head.last_idx);
  assign pop       = load && beat_last;

  always_comb begin
    beat       = cfg.esc_code;
    phase_next = phase;
    idx_next   = idx;
    unique case (phase)
      PH_ESC: begin
        beat       = cfg.esc_code;
        phase_next = PH_HI;
      end
      PH_HI: begin
        beat       = hex_upper(cur[7:4]);
        phase_next = PH_LO;
      end
      PH_LO: begin
        beat       = hex_upper(cur[3:0]);
        phase_next = PH_ESC;
        idx_next   = idx + 1'b1;
      end
      default: begin
        beat       = cfg.esc_code;
        phase_next = PH_ESC;
      end
    endcase
    if (head.keep) beat = head.bytes[0];
    if (beat_last) begin
      phase_next = PH_ESC;
      idx_next   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_ESC;
      idx      <= 2'd0;
      m_tvalid <= 1'b0;
    end else if (load) begin
      phase    <= phase_next;
      idx      <= idx_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= beat;
      m_tlast <= beat_last;
    end
  end

endmodule

// ===== rtl/percent_encoder_utf8.sv =====
// Percent encoder with UTF-8 support: top level, config registers, assertions.
// Depends on penc_pkg, penc_front, penc_fifo, penc_back.
// An accepted character is written into the descriptor queue, then its first byte is
//   loaded into the output register when the queue and the output register are free.
// Throughput: one output byte per cycle, set by the output register, while m_tready is high
//   and the queue is not empty; a character becomes 1 (kept), 3, 6, 9 or 12 output bytes. Input is taken while
//   the QUEUE_DEPTH-entry descriptor queue has room.
// Reset (rst, synchronous): empties the queue, drops m_tvalid, restores config.
module percent_encoder_utf8 #(
  parameter int QUEUE_DEPTH = penc_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream, one character per transaction
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,   // [20:0] char_value, [23:21] zero
  // output stream, one byte per transaction
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [7:0] out_byte
  output logic                              m_tlast,   // last_of_item
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [penc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [penc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import penc_pkg::*;

  cfg_t    cfg;
  desc_t   wr_desc, head;
  q_stat_t q_stat;
  logic    push, pop;

  // config writes always complete; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.esc_code    <= ESCAPE_RESET;
      cfg.wide_source <= 1'b0;
      cfg.keep_set    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ESC_CODE:    cfg.esc_code          <= cfg_data[7:0];
        CFG_WIDE_SOURCE: cfg.wide_source       <= cfg_data[0];
        CFG_KEEP_SET_W0: cfg.keep_set[63:0]    <= cfg_data;
        CFG_KEEP_SET_W1: cfg.keep_set[127:64]  <= cfg_data;
        CFG_KEEP_SET_W2: cfg.keep_set[191:128] <= cfg_data;
        CFG_KEEP_SET_W3: cfg.keep_set[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: classify and UTF-8 encode into a descriptor
  penc_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .char_value (s_tdata[CHAR_W-1:0]),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .push       (push),
    .desc       (wr_desc)
  );

  // decoupling queue
  penc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_desc (wr_desc),
    .pop     (pop),
    .rd_desc (head),
    .q_stat  (q_stat)
  );

  // back: escape sequencer and output register
  penc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // queue can never report full and empty together
  a_q_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  // an accepted character is held in the queue at the next edge
  a_push_held: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !q_stat.empty)
    else $error("accepted character lost from queue");

  // bytes of one character stream without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("gap inside an encoded character");

endmodule
